FILE: hdl/bfhp_pkg.sv
// shared types and constants for the binary frame header parser
`timescale 1ns / 1ps

package bfhp_pkg;

  localparam int MAX_COMMAND_BYTES_DEF = 256;

  localparam logic [7:0] FRAME_MAGIC [8] = '{8'h59, 8'h41, 8'h0a, 8'h00,
                                             8'h00, 8'h00, 8'h52, 8'h50};
  localparam logic [7:0] CMD_MARKER = 8'h7e;
  localparam logic [7:0] CMD_DATA   = 8'h64;
  localparam logic [31:0] CMD_HDR_BYTES = 32'd8;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_MAGIC     = 3'd1;
  localparam logic [2:0] STATUS_BLOCK_HDR = 3'd2;
  localparam logic [2:0] STATUS_REPLY_LEN = 3'd3;
  localparam logic [2:0] STATUS_MARKER    = 3'd4;
  localparam logic [2:0] STATUS_TOO_BIG   = 3'd5;
  localparam logic [2:0] STATUS_COMMAND   = 3'd6;
  localparam logic [2:0] STATUS_NEGATIVE  = 3'd7;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } bfhp_result_t;

endpackage

FILE: hdl/bfhp_parser.sv
// frame parsing state machine: one byte per transaction, at most one result
`timescale 1ns / 1ps

module bfhp_parser #(
  parameter int MAX_COMMAND_BYTES = bfhp_pkg::MAX_COMMAND_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  output logic                 res_valid,
  output bfhp_pkg::bfhp_result_t res
);
  import bfhp_pkg::*;

  localparam int POS_W = ($clog2(MAX_COMMAND_BYTES + 1) > 4) ?
                         $clog2(MAX_COMMAND_BYTES + 1) : 4;
  localparam logic [31:0] MAX_BODY = 32'(MAX_COMMAND_BYTES);

  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_BLOCK   = 4'd1;
  localparam logic [3:0] PH_LENS    = 4'd2;
  localparam logic [3:0] PH_REPLY   = 4'd3;
  localparam logic [3:0] PH_CMD     = 4'd4;
  localparam logic [3:0] PH_BODY    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;

  logic [3:0]       phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       block_total, block_total_next;
  logic [7:0]       block_index, block_index_next;
  logic [31:0]      length_word, length_word_next;
  logic [40:0]      length_sum, length_sum_next;
  logic [31:0]      first_length, first_length_next;
  logic [31:0]      payload_left, payload_left_next;
  logic             group_bad, group_bad_next;
  logic [7:0]       command_byte, command_byte_next;

  logic [POS_W-1:0] pos_inc;
  logic             bad;
  logic [31:0]      word_or;
  logic [31:0]      left_dec;
  logic [31:0]      body;
  logic             fail_en;
  logic [2:0]       fail_code;
  logic             finish_en;
  logic [31:0]      finish_body;
  logic [32:0]      finish_sub;
  logic [41:0]      total;

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    block_total_next   = block_total;
    block_index_next   = block_index;
    length_word_next   = length_word;
    length_sum_next    = length_sum;
    first_length_next  = first_length;
    payload_left_next  = payload_left;
    group_bad_next     = group_bad;
    command_byte_next  = command_byte;
    res_valid          = 1'b0;
    res                = '0;
    fail_en            = 1'b0;
    fail_code          = STATUS_OK;
    finish_en          = 1'b0;
    finish_body        = '0;
    finish_sub         = '0;
    total              = '0;
    bad                = group_bad;

    pos_inc  = byte_position + POS_W'(1);
    word_or  = length_word | ({24'd0, data_byte} << {byte_position[1:0], 3'b000});
    left_dec = (payload_left != 32'd0) ? payload_left - 32'd1 : payload_left;
    body     = first_length - CMD_HDR_BYTES;

    unique case (phase)
      PH_MAGIC: begin
        bad = group_bad | (data_byte != FRAME_MAGIC[byte_position[2:0]]);
        group_bad_next = bad;
        byte_position_next = pos_inc;
        if (pos_inc >= POS_W'(8)) begin
          if (bad) begin
            fail_en   = 1'b1;
            fail_code = STATUS_MAGIC;
          end else begin
            byte_position_next = '0;
            phase_next = PH_BLOCK;
          end
        end
      end
      PH_BLOCK: begin
        if (byte_position == '0) begin
          block_total_next = data_byte;
        end else if (byte_position == POS_W'(1) && data_byte != 8'd1) begin
          bad = 1'b1;
        end
        group_bad_next = bad;
        byte_position_next = pos_inc;
        if (pos_inc >= POS_W'(10)) begin
          if (bad) begin
            fail_en   = 1'b1;
            fail_code = STATUS_BLOCK_HDR;
          end else begin
            byte_position_next = '0;
            length_sum_next    = '0;
            length_word_next   = '0;
            first_length_next  = '0;
            block_index_next   = '0;
            phase_next = (block_total_next != 8'd0) ? PH_LENS : PH_REPLY;
          end
        end
      end
      PH_LENS: begin
        length_word_next = word_or;
        byte_position_next = pos_inc;
        if (pos_inc >= POS_W'(4)) begin
          length_sum_next = length_sum + {9'd0, word_or};
          if (block_index == 8'd0) begin
            first_length_next = word_or;
          end
          length_word_next   = '0;
          byte_position_next = '0;
          block_index_next   = block_index + 8'd1;
          if ({1'b0, block_index} + 9'd1 >= {1'b0, block_total}) begin
            phase_next = PH_REPLY;
          end
        end
      end
      PH_REPLY: begin
        bad = group_bad | (data_byte != 8'd0);
        group_bad_next = bad;
        byte_position_next = pos_inc;
        if (pos_inc >= POS_W'(4)) begin
          if (bad) begin
            fail_en   = 1'b1;
            fail_code = STATUS_REPLY_LEN;
          end else begin
            byte_position_next = '0;
            phase_next = PH_CMD;
          end
        end
      end
      PH_CMD: begin
        if (byte_position == POS_W'(4) && data_byte != CMD_MARKER) begin
          bad = 1'b1;
        end else if (byte_position == POS_W'(5)) begin
          command_byte_next = data_byte;
        end
        group_bad_next = bad;
        byte_position_next = pos_inc;
        if (pos_inc >= POS_W'(8)) begin
          byte_position_next = '0;
          if (bad) begin
            fail_en   = 1'b1;
            fail_code = STATUS_MARKER;
          end else if (command_byte_next == 8'd0) begin
            // command sits in a separate body
            if (body > MAX_BODY) begin
              fail_en   = 1'b1;
              fail_code = STATUS_TOO_BIG;
            end else if (body == 32'd0) begin
              fail_en   = 1'b1;
              fail_code = STATUS_COMMAND;
            end else begin
              payload_left_next = body;
              phase_next = PH_BODY;
            end
          end else if (command_byte_next != CMD_DATA) begin
            fail_en   = 1'b1;
            fail_code = STATUS_COMMAND;
          end else begin
            finish_en   = 1'b1;
            finish_body = '0;
          end
        end
      end
      PH_BODY: begin
        if (byte_position == '0) begin
          command_byte_next = data_byte;
        end
        byte_position_next = pos_inc;
        payload_left_next = left_dec;
        if (left_dec == 32'd0) begin
          byte_position_next = '0;
          if (command_byte_next != CMD_DATA) begin
            fail_en   = 1'b1;
            fail_code = STATUS_COMMAND;
          end else begin
            finish_en   = 1'b1;
            finish_body = body;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = data_byte;
        res.last           = (payload_left <= 32'd1);
        payload_left_next  = left_dec;
        if (left_dec == 32'd0) begin
          phase_next = PH_MAGIC;
          byte_position_next = '0;
        end
      end
      default: begin
        phase_next = PH_MAGIC;
        byte_position_next = '0;
        group_bad_next = 1'b0;
      end
    endcase

    // header done: payload length is sum - 8 - body, checked for range
    if (finish_en) begin
      finish_sub = {1'b0, CMD_HDR_BYTES} + {1'b0, finish_body};
      total = {1'b0, length_sum} - {9'd0, finish_sub};
      byte_position_next = '0;
      group_bad_next = 1'b0;
      if (total[41] || total[40:32] != 9'd0) begin
        fail_en   = 1'b1;
        fail_code = STATUS_NEGATIVE;
      end else begin
        payload_left_next  = total[31:0];
        phase_next         = (total[31:0] != 32'd0) ? PH_PAYLOAD : PH_MAGIC;
        res_valid          = 1'b1;
        res.kind           = KIND_VERDICT;
        res.status         = STATUS_OK;
        res.payload_length = total[31:0];
      end
    end

    if (fail_en) begin
      phase_next         = PH_MAGIC;
      byte_position_next = '0;
      group_bad_next     = 1'b0;
      res_valid          = 1'b1;
      res                = '0;
      res.kind           = KIND_VERDICT;
      res.status         = fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      byte_position <= '0;
      block_total   <= '0;
      block_index   <= '0;
      length_word   <= '0;
      length_sum    <= '0;
      first_length  <= '0;
      payload_left  <= '0;
      group_bad     <= 1'b0;
      command_byte  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      block_total   <= block_total_next;
      block_index   <= block_index_next;
      length_word   <= length_word_next;
      length_sum    <= length_sum_next;
      first_length  <= first_length_next;
      payload_left  <= payload_left_next;
      group_bad     <= group_bad_next;
      command_byte  <= command_byte_next;
    end
  end

endmodule

FILE: hdl/bfhp_out_reg.sv
// result register between the parser and the output channel
`timescale 1ns / 1ps

module bfhp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   res_valid,
  input  bfhp_pkg::bfhp_result_t res,
  output logic                   step,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bfhp_pkg::bfhp_result_t out_res
);
  import bfhp_pkg::*;

  logic out_valid_next;

  // a new byte may enter whenever the held result leaves in the same cycle
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (step) begin
      out_valid_next = res_valid;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

endmodule

FILE: hdl/binary_frame_header_parser.sv
// Binary frame header parser, top level.
// The input channel (in_valid, in_ready, data_byte) takes one received byte per
// transaction. The parser checks the 8-byte magic, the block header, the
// little-endian block lengths, the zero reply word and the command header
// (with an optional command body), then emits one verdict transaction
// (kind 0) with a status and the payload length, and on success forwards the
// payload bytes (kind 1) with last set on the final one.
// On any error an error verdict is emitted on the last byte of the failing
// group and parsing restarts at the first magic byte.
// A result is registered and appears on the output in the cycle after the
// byte that causes it is accepted. Throughput: one byte per cycle unless the
// receiver stalls, set by the single parser state update and result register.
// When the receiver stalls, the held result stays in the result register and
// in_ready drops until it is taken; a byte that yields no result still needs
// the register free or draining.
// Reset (synchronous, active high) returns the parser to seeking the magic
// and empties the result register; no transaction is lost or repeated after.
`timescale 1ns / 1ps

module binary_frame_header_parser #(
  parameter int MAX_COMMAND_BYTES = bfhp_pkg::MAX_COMMAND_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [2:0]  status,
  output logic [31:0] payload_length,
  output logic [7:0]  payload_byte,
  output logic        last
);
  import bfhp_pkg::*;

  logic         step;
  logic         res_valid;
  bfhp_result_t res;
  bfhp_result_t out_res;

  bfhp_parser #(
    .MAX_COMMAND_BYTES(MAX_COMMAND_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .data_byte(data_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  bfhp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .res_valid(res_valid),
    .res      (res),
    .step     (step),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign kind           = out_res.kind;
  assign status         = out_res.status;
  assign payload_length = out_res.payload_length;
  assign payload_byte   = out_res.payload_byte;
  assign last           = out_res.last;

endmodule
